/* hdl/fcou_pkg.sv */
// ----------------------------------------------------------------------------
// fcou_pkg
// shared types, constants and tables of the fly camera orientation update
// ----------------------------------------------------------------------------
package fcou_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int VEC_ONE      = 65536;
  localparam int DEG90        = 90 * 65536;
  localparam int DEG180       = 180 * 65536;
  localparam int DEG360       = 360 * 65536;
  localparam int PITCH_LIMIT  = 89 * 65536;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int MOD_TOP      = 10;
  localparam int DIV_TOP      = 17;
  localparam int SQRT_LAST    = 31;
  localparam int XMUL_LAST    = 6;
  localparam int SQ_LAST      = 3;

  localparam logic [2:0] CMD_CURSOR = 3'd0;
  localparam logic [2:0] CMD_FWD    = 3'd1;
  localparam logic [2:0] CMD_BACK   = 3'd2;
  localparam logic [2:0] CMD_LEFT   = 3'd3;
  localparam logic [2:0] CMD_RIGHT  = 3'd4;

  localparam logic [2:0] REG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] REG_LOOK_SENS   = 3'd1;
  localparam logic [2:0] REG_UP_X        = 3'd2;
  localparam logic [2:0] REG_UP_Y        = 3'd3;
  localparam logic [2:0] REG_UP_Z        = 3'd4;

  typedef struct packed {
    logic        [31:0] move_speed;
    logic        [15:0] look_sensitivity;
    logic signed [17:0] up_x;
    logic signed [17:0] up_y;
    logic signed [17:0] up_z;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_DX, OP_MUL_DY, OP_PITCH, OP_MODFIX, OP_MODSTEP,
    OP_YAWSET, OP_CINIT, OP_CSTEP, OP_CDONE, OP_FX, OP_FZ, OP_FSET,
    OP_DIST_MUL, OP_DIST, OP_DMUL, OP_DADD, OP_XMUL, OP_NORM, OP_SQ,
    OP_SQRT_INIT, OP_SQRT, OP_DIV_INIT, OP_DIV, OP_DIV_DONE, OP_FINISH
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_MUL_DX, ST_MUL_DY, ST_PITCH, ST_MODFIX, ST_MOD,
    ST_YAWSET, ST_CINIT, ST_CSTEP, ST_CDONE, ST_FX, ST_FZ, ST_FSET,
    ST_XMUL, ST_NORM, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV,
    ST_DIV_DONE, ST_DIST_MUL, ST_DIST, ST_DMUL, ST_DADD, ST_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic       sel;
    logic [1:0] idx;
    logic [4:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       big;
  } dp_stat_t;

  // arctangent of 2^-i in Q16.16 degrees
  function automatic logic signed [32:0] atan_deg(input logic [4:0] i);
    logic signed [32:0] r;
    case (i)
      5'd0:    r = 33'sd2949120;
      5'd1:    r = 33'sd1740967;
      5'd2:    r = 33'sd919879;
      5'd3:    r = 33'sd466945;
      5'd4:    r = 33'sd234379;
      5'd5:    r = 33'sd117304;
      5'd6:    r = 33'sd58666;
      5'd7:    r = 33'sd29335;
      5'd8:    r = 33'sd14668;
      5'd9:    r = 33'sd7334;
      5'd10:   r = 33'sd3667;
      5'd11:   r = 33'sd1833;
      5'd12:   r = 33'sd917;
      5'd13:   r = 33'sd458;
      5'd14:   r = 33'sd229;
      5'd15:   r = 33'sd115;
      5'd16:   r = 33'sd57;
      5'd17:   r = 33'sd29;
      5'd18:   r = 33'sd14;
      5'd19:   r = 33'sd7;
      5'd20:   r = 33'sd4;
      5'd21:   r = 33'sd2;
      5'd22:   r = 33'sd1;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/fcou_regs.sv */
// ----------------------------------------------------------------------------
// fcou_regs
// configuration register bank behind the apb port
// ----------------------------------------------------------------------------
module fcou_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fcou_pkg::cfg_t     cfg_o
);
  import fcou_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_speed       <= 32'd163840;
      cfg_q.look_sensitivity <= 16'd6554;
      cfg_q.up_x             <= 18'sd0;
      cfg_q.up_y             <= 18'sd65536;
      cfg_q.up_z             <= 18'sd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MOVE_SPEED: cfg_q.move_speed       <= pwdata;
        REG_LOOK_SENS:  cfg_q.look_sensitivity <= pwdata[15:0];
        REG_UP_X:       cfg_q.up_x             <= pwdata[17:0];
        REG_UP_Y:       cfg_q.up_y             <= pwdata[17:0];
        REG_UP_Z:       cfg_q.up_z             <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MOVE_SPEED: prdata = cfg_q.move_speed;
      REG_LOOK_SENS:  prdata = {16'd0, cfg_q.look_sensitivity};
      REG_UP_X:       prdata = {14'd0, cfg_q.up_x};
      REG_UP_Y:       prdata = {14'd0, cfg_q.up_y};
      REG_UP_Z:       prdata = {14'd0, cfg_q.up_z};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/fcou_ctrl.sv */
// ----------------------------------------------------------------------------
// fcou_ctrl
// sequencer: steps the datapath through each transaction and runs handshakes
// ----------------------------------------------------------------------------
module fcou_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fcou_pkg::dp_stat_t  stat_i,
  output fcou_pkg::dp_cmd_t   ctl_o
);
  import fcou_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       sel_q, sel_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    ctl_o.op    = OP_NONE;
    ctl_o.sel   = sel_q;
    ctl_o.idx   = idx_q;
    ctl_o.cnt   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_d = '0;
        case (stat_i.cmd) inside
          CMD_CURSOR:          state_d = ST_MUL_DX;
          CMD_FWD, CMD_BACK:   state_d = ST_DIST_MUL;
          CMD_LEFT, CMD_RIGHT: state_d = ST_XMUL;
          default:             state_d = ST_FINISH;
        endcase
      end
      ST_MUL_DX: begin
        ctl_o.op = OP_MUL_DX;
        state_d  = ST_MUL_DY;
      end
      ST_MUL_DY: begin
        ctl_o.op = OP_MUL_DY;
        state_d  = ST_PITCH;
      end
      ST_PITCH: begin
        ctl_o.op = OP_PITCH;
        state_d  = ST_MODFIX;
      end
      ST_MODFIX: begin
        ctl_o.op = OP_MODFIX;
        cnt_d    = 5'(MOD_TOP);
        state_d  = ST_MOD;
      end
      ST_MOD: begin
        ctl_o.op = OP_MODSTEP;
        if (cnt_q == 5'd0) begin
          state_d = ST_YAWSET;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      ST_YAWSET: begin
        ctl_o.op = OP_YAWSET;
        sel_d    = 1'b0;
        state_d  = ST_CINIT;
      end
      ST_CINIT: begin
        ctl_o.op = OP_CINIT;
        cnt_d    = '0;
        state_d  = ST_CSTEP;
      end
      ST_CSTEP: begin
        ctl_o.op = OP_CSTEP;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = ST_CDONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_CDONE: begin
        ctl_o.op = OP_CDONE;
        if (sel_q) begin
          state_d = ST_FX;
        end else begin
          sel_d   = 1'b1;
          state_d = ST_CINIT;
        end
      end
      ST_FX: begin
        ctl_o.op = OP_FX;
        state_d  = ST_FZ;
      end
      ST_FZ: begin
        ctl_o.op = OP_FZ;
        state_d  = ST_FSET;
      end
      ST_FSET: begin
        ctl_o.op = OP_FSET;
        state_d  = ST_FINISH;
      end
      ST_XMUL: begin
        ctl_o.op = OP_XMUL;
        if (cnt_q == 5'(XMUL_LAST)) begin
          state_d = ST_NORM;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_NORM: begin
        ctl_o.op = OP_NORM;
        if (!stat_i.big) begin
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        ctl_o.op = OP_SQ;
        if (cnt_q == 5'(SQ_LAST)) begin
          state_d = ST_SQRT_INIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_SQRT_INIT: begin
        ctl_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        ctl_o.op = OP_SQRT;
        if (cnt_q == 5'(SQRT_LAST)) begin
          idx_d   = '0;
          state_d = ST_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DIV_INIT: begin
        ctl_o.op = OP_DIV_INIT;
        cnt_d    = 5'(DIV_TOP);
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.op = OP_DIV;
        if (cnt_q == 5'd0) begin
          state_d = ST_DIV_DONE;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      ST_DIV_DONE: begin
        ctl_o.op = OP_DIV_DONE;
        if (idx_q == 2'd2) begin
          state_d = ST_DIST_MUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIST_MUL: begin
        ctl_o.op = OP_DIST_MUL;
        state_d  = ST_DIST;
      end
      ST_DIST: begin
        ctl_o.op = OP_DIST;
        idx_d    = '0;
        state_d  = ST_DMUL;
      end
      ST_DMUL: begin
        ctl_o.op = OP_DMUL;
        state_d  = ST_DADD;
      end
      ST_DADD: begin
        ctl_o.op = OP_DADD;
        if (idx_q == 2'd2) begin
          state_d = ST_FINISH;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_DMUL;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hdl/fcou_dp.sv */
// ----------------------------------------------------------------------------
// fcou_dp
// datapath: camera state, shared multiplier, cordic, root and divide units
// ----------------------------------------------------------------------------
module fcou_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcou_pkg::dp_cmd_t   ctl_i,
  output fcou_pkg::dp_stat_t  stat_o,
  input  fcou_pkg::cfg_t      cfg_i,
  input  logic [2:0]          cmd_i,
  input  logic signed [15:0]  cursor_x_i,
  input  logic signed [15:0]  cursor_y_i,
  input  logic [23:0]         time_step_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [17:0]  front_x_o,
  output logic signed [17:0]  front_y_o,
  output logic signed [17:0]  front_z_o
);
  import fcou_pkg::*;

  localparam logic signed [36:0] BIG_POS = 37'sd1073741824;
  localparam logic signed [36:0] BIG_NEG = -37'sd1073741824;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // architectural state
  logic signed [31:0] pos_q   [3];
  logic signed [17:0] front_q [3];
  logic signed [31:0] yaw_q, pitch_q;
  logic signed [15:0] prev_x_q, prev_y_q;
  logic               first_q;

  // working registers
  logic [2:0]         cmd_q;
  logic [23:0]        tstep_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [65:0] prod_q;
  logic signed [36:0] mod_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] ang_q;
  logic               flip_q;
  logic signed [31:0] sin_yaw_q, cos_yaw_q, sin_pit_q, cos_pit_q;
  logic signed [36:0] cr_q    [3];
  logic [63:0]        sum_q, sq_v_q, sq_r_q;
  logic [49:0]        rem_q;
  logic [17:0]        quo_q;
  logic signed [17:0] side_q  [3];
  logic [31:0]        dist_q;
  logic signed [31:0] out_pos_q   [3];
  logic signed [17:0] out_front_q [3];

  // combinational helpers
  logic signed [32:0] mul_a, mul_b;
  logic               use_side, negate;
  logic signed [17:0] vec_sel;
  logic [2:0]         xj;
  logic signed [31:0] cin_ang;
  logic signed [32:0] fold_ang;
  logic               fold_flip;
  logic signed [33:0] cx_sh, cy_sh;
  logic signed [33:0] cd_x, cd_y;
  logic signed [31:0] cd_xc, cd_yc;
  logic signed [37:0] pit_sum;
  logic signed [36:0] mod_sub;
  logic [63:0]        sq_bit, sq_try;
  logic [5:0]         sq_shift;
  logic [49:0]        div_sh;
  logic signed [36:0] div_src;
  logic [30:0]        div_mag;
  logic [56:0]        dist_sum;
  logic signed [65:0] dd_full;
  logic signed [35:0] dd, pos_sum;
  logic signed [31:0] pos_cur;
  logic [17:0]        q_sat;

  function automatic logic signed [17:0] to_vec(input logic signed [65:0] q30);
    logic signed [65:0] t;
    logic signed [17:0] r;
    t = (q30 + 66'sd8192) >>> 14;
    if (t > 66'sd65536) begin
      r = 18'sd65536;
    end else if (t < -66'sd65536) begin
      r = -18'sd65536;
    end else begin
      r = t[17:0];
    end
    return r;
  endfunction

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    return (v + 66'sd536870912) >>> 30;
  endfunction

  assign use_side = (cmd_q == CMD_LEFT) || (cmd_q == CMD_RIGHT);
  assign negate   = (cmd_q == CMD_BACK) || (cmd_q == CMD_LEFT);
  assign vec_sel  = use_side ? side_q[ctl_i.idx] : front_q[ctl_i.idx];
  assign xj       = 3'(ctl_i.cnt - 5'd1);

  assign stat_o.cmd = cmd_q;
  assign stat_o.big = (cr_q[0] >= BIG_POS) || (cr_q[0] <= BIG_NEG) ||
                      (cr_q[1] >= BIG_POS) || (cr_q[1] <= BIG_NEG) ||
                      (cr_q[2] >= BIG_POS) || (cr_q[2] <= BIG_NEG);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl_i.op)
      OP_MUL_DX: begin
        mul_a = 33'(dx_q);
        mul_b = {17'd0, cfg_i.look_sensitivity};
      end
      OP_MUL_DY: begin
        mul_a = 33'(dy_q);
        mul_b = {17'd0, cfg_i.look_sensitivity};
      end
      OP_FX: begin
        mul_a = 33'(cos_yaw_q);
        mul_b = 33'(cos_pit_q);
      end
      OP_FZ: begin
        mul_a = 33'(sin_yaw_q);
        mul_b = 33'(cos_pit_q);
      end
      OP_DIST_MUL: begin
        mul_a = {1'b0, cfg_i.move_speed};
        mul_b = {9'd0, tstep_q};
      end
      OP_DMUL: begin
        mul_a = {1'b0, dist_q};
        mul_b = 33'(vec_sel);
      end
      OP_XMUL: begin
        case (ctl_i.cnt)
          5'd0: begin mul_a = 33'(front_q[1]); mul_b = 33'(cfg_i.up_z); end
          5'd1: begin mul_a = 33'(front_q[2]); mul_b = 33'(cfg_i.up_y); end
          5'd2: begin mul_a = 33'(front_q[2]); mul_b = 33'(cfg_i.up_x); end
          5'd3: begin mul_a = 33'(front_q[0]); mul_b = 33'(cfg_i.up_z); end
          5'd4: begin mul_a = 33'(front_q[0]); mul_b = 33'(cfg_i.up_y); end
          5'd5: begin mul_a = 33'(front_q[1]); mul_b = 33'(cfg_i.up_x); end
          default: ;
        endcase
      end
      OP_SQ: begin
        if (ctl_i.cnt < 5'd3) begin
          mul_a = cr_q[ctl_i.cnt[1:0]][32:0];
          mul_b = cr_q[ctl_i.cnt[1:0]][32:0];
        end
      end
      default: ;
    endcase
  end

  // angle folding, cordic step and other per-op arithmetic
  always_comb begin
    cin_ang   = ctl_i.sel ? pitch_q : yaw_q;
    fold_ang  = 33'(cin_ang);
    fold_flip = 1'b0;
    if (cin_ang > 32'(DEG90)) begin
      fold_ang  = 33'(cin_ang) - 33'(DEG180);
      fold_flip = 1'b1;
    end else if (cin_ang < -32'(DEG90)) begin
      fold_ang  = 33'(cin_ang) + 33'(DEG180);
      fold_flip = 1'b1;
    end
    cx_sh = cx_q >>> ctl_i.cnt;
    cy_sh = cy_q >>> ctl_i.cnt;
    cd_x  = flip_q ? -cx_q : cx_q;
    cd_y  = flip_q ? -cy_q : cy_q;
    cd_xc = (cd_x > ONE_Q30) ? 32'(ONE_Q30) : ((cd_x < -ONE_Q30) ? -32'(ONE_Q30)
                                                                 : cd_x[31:0]);
    cd_yc = (cd_y > ONE_Q30) ? 32'(ONE_Q30) : ((cd_y < -ONE_Q30) ? -32'(ONE_Q30)
                                                                 : cd_y[31:0]);
    pit_sum  = 38'(pitch_q) + prod_q[37:0];
    mod_sub  = 37'(DEG360) << ctl_i.cnt;
    sq_shift = 6'd62 - {ctl_i.cnt, 1'b0};
    sq_bit   = 64'd1 << sq_shift;
    sq_try   = sq_r_q + sq_bit;
    div_sh   = 50'(sq_r_q[31:0]) << ctl_i.cnt;
    div_src  = cr_q[ctl_i.idx];
    div_mag  = (div_src < 0) ? 31'(-div_src) : div_src[30:0];
    q_sat    = (quo_q > 18'd65536) ? 18'd65536 : quo_q;
    dist_sum = 57'(prod_q[55:0]) + 57'd8388608;
    dd_full  = (prod_q + 66'sd32768) >>> 16;
    dd       = negate ? -dd_full[35:0] : dd_full[35:0];
    pos_cur  = pos_q[ctl_i.idx];
    pos_sum  = 36'(pos_cur) + dd;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]   <= '0;
      pos_q[1]   <= '0;
      pos_q[2]   <= '0;
      front_q[0] <= '0;
      front_q[1] <= '0;
      front_q[2] <= -18'sd65536;
      yaw_q      <= -32'(DEG90);
      pitch_q    <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      first_q    <= 1'b1;
    end else begin
      unique case (ctl_i.op)
        OP_LOAD: begin
          if (cmd_i == CMD_CURSOR) begin
            prev_x_q <= cursor_x_i;
            prev_y_q <= cursor_y_i;
            first_q  <= 1'b0;
          end
        end
        OP_PITCH: begin
          if (pit_sum > 38'(PITCH_LIMIT)) begin
            pitch_q <= 32'(PITCH_LIMIT);
          end else if (pit_sum < -38'(PITCH_LIMIT)) begin
            pitch_q <= -32'(PITCH_LIMIT);
          end else begin
            pitch_q <= pit_sum[31:0];
          end
        end
        OP_YAWSET: yaw_q <= 32'(mod_q - 37'(DEG180));
        OP_FZ:     front_q[0] <= to_vec(rnd30(prod_q));
        OP_FSET: begin
          front_q[2] <= to_vec(rnd30(prod_q));
          front_q[1] <= to_vec(66'(sin_pit_q));
        end
        OP_DADD: begin
          if (pos_sum > 36'sd2147483647) begin
            pos_q[ctl_i.idx] <= 32'sh7fffffff;
          end else if (pos_sum < -36'sd2147483648) begin
            pos_q[ctl_i.idx] <= 32'sh80000000;
          end else begin
            pos_q[ctl_i.idx] <= pos_sum[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_LOAD: begin
        cmd_q   <= cmd_i;
        tstep_q <= time_step_i;
        if (first_q) begin
          dx_q <= '0;
          dy_q <= '0;
        end else begin
          dx_q <= 17'(cursor_x_i) - 17'(prev_x_q);
          dy_q <= 17'(prev_y_q) - 17'(cursor_y_i);
        end
      end
      OP_MUL_DY: mod_q <= 37'(yaw_q) + prod_q[36:0] + 37'(DEG180);
      OP_MODFIX: begin
        if (mod_q < 0) begin
          mod_q <= mod_q + (37'(DEG360) << MOD_TOP);
        end
      end
      OP_MODSTEP: begin
        if (mod_q >= mod_sub) begin
          mod_q <= mod_q - mod_sub;
        end
      end
      OP_CINIT: begin
        cx_q   <= 34'(CORDIC_GAIN);
        cy_q   <= '0;
        ang_q  <= fold_ang;
        flip_q <= fold_flip;
      end
      OP_CSTEP: begin
        if (ang_q >= 0) begin
          cx_q  <= cx_q - cy_sh;
          cy_q  <= cy_q + cx_sh;
          ang_q <= ang_q - atan_deg(ctl_i.cnt);
        end else begin
          cx_q  <= cx_q + cy_sh;
          cy_q  <= cy_q - cx_sh;
          ang_q <= ang_q + atan_deg(ctl_i.cnt);
        end
      end
      OP_CDONE: begin
        if (ctl_i.sel) begin
          cos_pit_q <= cd_xc;
          sin_pit_q <= cd_yc;
        end else begin
          cos_yaw_q <= cd_xc;
          sin_yaw_q <= cd_yc;
        end
      end
      OP_XMUL: begin
        if (ctl_i.cnt != 5'd0) begin
          if (xj[0]) begin
            cr_q[xj[2:1]] <= cr_q[xj[2:1]] - prod_q[36:0];
          end else begin
            cr_q[xj[2:1]] <= prod_q[36:0];
          end
        end
      end
      OP_NORM: begin
        if (stat_o.big) begin
          cr_q[0] <= cr_q[0] >>> 1;
          cr_q[1] <= cr_q[1] >>> 1;
          cr_q[2] <= cr_q[2] >>> 1;
        end
      end
      OP_SQ: begin
        if (ctl_i.cnt == 5'd1) begin
          sum_q <= prod_q[63:0];
        end else if (ctl_i.cnt != 5'd0) begin
          sum_q <= sum_q + prod_q[63:0];
        end
      end
      OP_SQRT_INIT: begin
        sq_v_q <= sum_q;
        sq_r_q <= '0;
      end
      OP_SQRT: begin
        if (sq_v_q >= sq_try) begin
          sq_v_q <= sq_v_q - sq_try;
          sq_r_q <= (sq_r_q >> 1) + sq_bit;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
      end
      OP_DIV_INIT: begin
        rem_q <= {3'd0, div_mag, 16'd0} + 50'(sq_r_q[31:1]);
        quo_q <= '0;
      end
      OP_DIV: begin
        if (rem_q >= div_sh) begin
          rem_q               <= rem_q - div_sh;
          quo_q[ctl_i.cnt]    <= 1'b1;
        end
      end
      OP_DIV_DONE: begin
        if (sq_r_q == 64'd0) begin
          side_q[ctl_i.idx] <= '0;
        end else if (div_src < 0) begin
          side_q[ctl_i.idx] <= -$signed(q_sat);
        end else begin
          side_q[ctl_i.idx] <= $signed(q_sat);
        end
      end
      OP_DIST: dist_q <= dist_sum[55:24];
      OP_FINISH: begin
        out_pos_q[0]   <= pos_q[0];
        out_pos_q[1]   <= pos_q[1];
        out_pos_q[2]   <= pos_q[2];
        out_front_q[0] <= front_q[0];
        out_front_q[1] <= front_q[1];
        out_front_q[2] <= front_q[2];
      end
      default: ;
    endcase
  end

  assign pos_x_o   = out_pos_q[0];
  assign pos_y_o   = out_pos_q[1];
  assign pos_z_o   = out_pos_q[2];
  assign front_x_o = out_front_q[0];
  assign front_y_o = out_front_q[1];
  assign front_z_o = out_front_q[2];

endmodule

/* hdl/fly_camera_orientation_update_top.sv */
// ----------------------------------------------------------------------------
// fly_camera_orientation_update_top
// euler-angle fly camera: cursor look and movement, one result per transaction
// ----------------------------------------------------------------------------
// cursor transaction: runs the modulo sweep and two 16-step cordic runs
// forward/backward: three multiply-and-add passes on the shared multiplier
// left/right: runs the 32-step root and three 18-step divides
// one transaction in flight; the next is taken while a result waits in the output register
// reset: position zero, front (0,0,-1), yaw -90, pitch 0, first cursor sample pending
module fly_camera_orientation_update_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [15:0] cursor_x_i,
  input  logic signed [15:0] cursor_y_i,
  input  logic [23:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [17:0] front_x_o,
  output logic signed [17:0] front_y_o,
  output logic signed [17:0] front_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fcou_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  ctl;
  dp_stat_t stat;

  fcou_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcou_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  fcou_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .cfg_i       (cfg),
    .cmd_i       (cmd_i),
    .cursor_x_i  (cursor_x_i),
    .cursor_y_i  (cursor_y_i),
    .time_step_i (time_step_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .front_x_o   (front_x_o),
    .front_y_o   (front_y_o),
    .front_z_o   (front_z_o)
  );

endmodule
